/* design/rpd_pkg.sv */
// Shared types and constants for the relative pose delta unit.
// Holds the transaction structs, fixed-point widths and the CORDIC arctangent table.
// No dependencies.
package rpd_pkg;

	localparam int POS_W = 32;
	localparam int ANG_W = 16;
	localparam int DELTA_W = POS_W + 1;
	localparam int ZBASE_W = 32;
	localparam int Z_W = ZBASE_W + 1;
	localparam int TRIG_W = 34;
	localparam int TRIG_FRAC = 30;
	localparam int CORDIC_STEPS = 30;
	localparam int ITER_PER_STAGE = 2;
	localparam int CORDIC_STAGES = CORDIC_STEPS / ITER_PER_STAGE;
	localparam int PROD_W = DELTA_W + TRIG_W;
	localparam int SUM_W = PROD_W + 1;
	localparam int SHIFT_W = SUM_W - TRIG_FRAC;

	// Reciprocal of the CORDIC gain in Q4.30.
	localparam logic signed [TRIG_W-1:0] CORDIC_K = TRIG_W'(34'sh026DD3B6A);
	localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) <<< (TRIG_FRAC - 1);
	localparam logic signed [SHIFT_W-1:0] POS_MAX = SHIFT_W'((64'sd1 <<< (POS_W - 1)) - 1);
	localparam logic signed [SHIFT_W-1:0] POS_MIN = -POS_MAX - SHIFT_W'(1);

	// Arctangent of 2^-i as a fraction of a full turn, scaled by 2^32.
	localparam logic [ZBASE_W-1:0] ATAN_TURNS [CORDIC_STEPS] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
		32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
		32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
	};

	typedef struct packed {
		logic signed [POS_W-1:0] cur_x;
		logic signed [POS_W-1:0] cur_y;
		logic signed [ANG_W-1:0] cur_heading;
		logic signed [POS_W-1:0] prev_x;
		logic signed [POS_W-1:0] prev_y;
		logic signed [ANG_W-1:0] prev_heading;
	} pose_t;

	typedef struct packed {
		logic signed [POS_W-1:0] forward;
		logic signed [POS_W-1:0] lateral;
		logic signed [ANG_W-1:0] turn;
		logic saturated;
	} delta_t;

	typedef struct packed {
		logic signed [DELTA_W-1:0] dx;
		logic signed [DELTA_W-1:0] dy;
		logic signed [ANG_W-1:0] turn;
		logic signed [TRIG_W-1:0] x;
		logic signed [TRIG_W-1:0] y;
		logic signed [Z_W-1:0] z;
	} rot_item_t;

endpackage

/* design/rpd_pre.sv */
// Front stage: position differences, heading change and CORDIC start vector.
// Depends on rpd_pkg.
module rpd_pre (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  rpd_pkg::pose_t in_item,
	output logic out_valid,
	input  logic out_ready,
	output rpd_pkg::rot_item_t out_item
);

	logic valid_s1;
	rpd_pkg::rot_item_t item_s1;
	rpd_pkg::rot_item_t start;
	logic [rpd_pkg::ZBASE_W-1:0] z_raw;
	logic fold;

	assign in_ready = !valid_s1 || out_ready;

	always_comb begin
		z_raw = {in_item.prev_heading, {(rpd_pkg::ZBASE_W - rpd_pkg::ANG_W){1'b0}}};
		// Outside the right half plane: move by half a turn and negate the start vector.
		fold = z_raw[rpd_pkg::ZBASE_W-1] ^ z_raw[rpd_pkg::ZBASE_W-2];
		start.dx = rpd_pkg::DELTA_W'(in_item.cur_x) - rpd_pkg::DELTA_W'(in_item.prev_x);
		start.dy = rpd_pkg::DELTA_W'(in_item.cur_y) - rpd_pkg::DELTA_W'(in_item.prev_y);
		start.turn = in_item.cur_heading - in_item.prev_heading;
		start.x = fold ? -rpd_pkg::CORDIC_K : rpd_pkg::CORDIC_K;
		start.y = '0;
		start.z = rpd_pkg::Z_W'($signed({z_raw[rpd_pkg::ZBASE_W-1] ^ fold,
			z_raw[rpd_pkg::ZBASE_W-2:0]}));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= start;
		end
	end

	assign out_valid = valid_s1;
	assign out_item = item_s1;

endmodule

/* design/rpd_cordic.sv */
// Unrolled CORDIC rotation, two micro-rotations per pipeline stage.
// Carries the position differences and heading change alongside. Depends on rpd_pkg.
module rpd_cordic (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  rpd_pkg::rot_item_t in_item,
	output logic out_valid,
	input  logic out_ready,
	output rpd_pkg::rot_item_t out_item
);

	localparam int STAGES = rpd_pkg::CORDIC_STAGES;

	logic valid_s [STAGES];
	rpd_pkg::rot_item_t item_s [STAGES];
	rpd_pkg::rot_item_t data_c [STAGES+1];
	rpd_pkg::rot_item_t step_out [STAGES];
	logic [STAGES:0] valid_c;
	logic [STAGES:0] rdy;

	assign data_c[0] = in_item;
	assign valid_c[0] = in_valid;
	assign rdy[STAGES] = out_ready;
	assign in_ready = rdy[0];

	for (genvar g = 0; g < STAGES; g++) begin : g_stage
		assign rdy[g] = !valid_s[g] || rdy[g+1];
		assign data_c[g+1] = item_s[g];
		assign valid_c[g+1] = valid_s[g];

		always_comb begin
			rpd_pkg::rot_item_t w;
			logic signed [rpd_pkg::TRIG_W-1:0] xs;
			logic signed [rpd_pkg::TRIG_W-1:0] ys;
			logic signed [rpd_pkg::Z_W-1:0] ang;
			w = data_c[g];
			for (int k = 0; k < rpd_pkg::ITER_PER_STAGE; k++) begin
				xs = w.x >>> (g * rpd_pkg::ITER_PER_STAGE + k);
				ys = w.y >>> (g * rpd_pkg::ITER_PER_STAGE + k);
				ang = $signed({1'b0, rpd_pkg::ATAN_TURNS[g * rpd_pkg::ITER_PER_STAGE + k]});
				if (!w.z[rpd_pkg::Z_W-1]) begin
					w.x = w.x - ys;
					w.y = w.y + xs;
					w.z = w.z - ang;
				end else begin
					w.x = w.x + ys;
					w.y = w.y - xs;
					w.z = w.z + ang;
				end
			end
			step_out[g] = w;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[g] <= 1'b0;
			end else if (rdy[g]) begin
				valid_s[g] <= valid_c[g];
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[g] && valid_c[g]) begin
				item_s[g] <= step_out[g];
			end
		end
	end

	assign out_valid = valid_c[STAGES];
	assign out_item = data_c[STAGES];

endmodule

/* design/rpd_rotate.sv */
// Back end: rotates the displacement by the cosine and sine, rounds and saturates.
// Three stages: products, rounded sums, clipping into the output register. Depends on rpd_pkg.
module rpd_rotate (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  rpd_pkg::rot_item_t in_item,
	output logic out_valid,
	input  logic out_ready,
	output rpd_pkg::delta_t out_item
);

	logic valid_s1;
	logic valid_s2;
	logic valid_s3;
	logic rdy1;
	logic rdy2;
	logic rdy3;

	logic signed [rpd_pkg::PROD_W-1:0] p_fc_s1;
	logic signed [rpd_pkg::PROD_W-1:0] p_fs_s1;
	logic signed [rpd_pkg::PROD_W-1:0] p_lc_s1;
	logic signed [rpd_pkg::PROD_W-1:0] p_ls_s1;
	logic signed [rpd_pkg::ANG_W-1:0] turn_s1;

	logic signed [rpd_pkg::SUM_W-1:0] fwd_sum_s2;
	logic signed [rpd_pkg::SUM_W-1:0] lat_sum_s2;
	logic signed [rpd_pkg::ANG_W-1:0] turn_s2;

	rpd_pkg::delta_t result_s3;

	logic signed [rpd_pkg::SHIFT_W-1:0] fwd_sh;
	logic signed [rpd_pkg::SHIFT_W-1:0] lat_sh;
	logic fwd_hi;
	logic fwd_lo;
	logic lat_hi;
	logic lat_lo;
	rpd_pkg::delta_t result;

	assign rdy3 = !valid_s3 || out_ready;
	assign rdy2 = !valid_s2 || rdy3;
	assign rdy1 = !valid_s1 || rdy2;
	assign in_ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (rdy1) begin
				valid_s1 <= in_valid;
			end
			if (rdy2) begin
				valid_s2 <= valid_s1;
			end
			if (rdy3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			p_fc_s1 <= $signed(in_item.dx) * $signed(in_item.x);
			p_fs_s1 <= $signed(in_item.dy) * $signed(in_item.y);
			p_lc_s1 <= $signed(in_item.dy) * $signed(in_item.x);
			p_ls_s1 <= $signed(in_item.dx) * $signed(in_item.y);
			turn_s1 <= in_item.turn;
		end
	end

	// Sums are exact at this width; adding half an LSB rounds ties toward plus infinity.
	always_ff @(posedge clk) begin
		if (rdy2 && valid_s1) begin
			fwd_sum_s2 <= rpd_pkg::SUM_W'(p_fc_s1) + rpd_pkg::SUM_W'(p_fs_s1)
				+ rpd_pkg::ROUND_HALF;
			lat_sum_s2 <= rpd_pkg::SUM_W'(p_lc_s1) - rpd_pkg::SUM_W'(p_ls_s1)
				+ rpd_pkg::ROUND_HALF;
			turn_s2 <= turn_s1;
		end
	end

	always_comb begin
		fwd_sh = fwd_sum_s2[rpd_pkg::SUM_W-1:rpd_pkg::TRIG_FRAC];
		lat_sh = lat_sum_s2[rpd_pkg::SUM_W-1:rpd_pkg::TRIG_FRAC];
		fwd_hi = fwd_sh > rpd_pkg::POS_MAX;
		fwd_lo = fwd_sh < rpd_pkg::POS_MIN;
		lat_hi = lat_sh > rpd_pkg::POS_MAX;
		lat_lo = lat_sh < rpd_pkg::POS_MIN;
		priority if (fwd_hi) begin
			result.forward = rpd_pkg::POS_MAX[rpd_pkg::POS_W-1:0];
		end else if (fwd_lo) begin
			result.forward = rpd_pkg::POS_MIN[rpd_pkg::POS_W-1:0];
		end else begin
			result.forward = fwd_sh[rpd_pkg::POS_W-1:0];
		end
		priority if (lat_hi) begin
			result.lateral = rpd_pkg::POS_MAX[rpd_pkg::POS_W-1:0];
		end else if (lat_lo) begin
			result.lateral = rpd_pkg::POS_MIN[rpd_pkg::POS_W-1:0];
		end else begin
			result.lateral = lat_sh[rpd_pkg::POS_W-1:0];
		end
		result.turn = turn_s2;
		result.saturated = fwd_hi || fwd_lo || lat_hi || lat_lo;
	end

	always_ff @(posedge clk) begin
		if (rdy3 && valid_s2) begin
			result_s3 <= result;
		end
	end

	assign out_valid = valid_s3;
	assign out_item = result_s3;

endmodule

/* design/relative_pose_delta_unit.sv */
// Relative pose delta unit: an accepted pose transaction passes 1 front stage, 15 CORDIC
// stages of two micro-rotations and 3 rotate stages on its way to delta_valid.
// Throughput is one transaction per cycle unless delta_ready holds the flow back; every stage
// holds under back-pressure and bubbles are squeezed out. Reset clears only the valid bits;
// no state is kept between poses. Depends on rpd_pkg, rpd_pre, rpd_cordic and rpd_rotate.
module relative_pose_delta_unit (
	input  logic clk,
	input  logic arst_n,
	input  logic pose_valid,
	output logic pose_ready,
	input  rpd_pkg::pose_t pose,
	output logic delta_valid,
	input  logic delta_ready,
	output rpd_pkg::delta_t delta
);

	logic pre_valid;
	logic pre_ready;
	rpd_pkg::rot_item_t pre_item;
	logic rot_valid;
	logic rot_ready;
	rpd_pkg::rot_item_t rot_item;

	rpd_pre u_pre (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pose_valid),
		.in_ready (pose_ready),
		.in_item  (pose),
		.out_valid(pre_valid),
		.out_ready(pre_ready),
		.out_item (pre_item)
	);

	rpd_cordic u_cordic (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pre_valid),
		.in_ready (pre_ready),
		.in_item  (pre_item),
		.out_valid(rot_valid),
		.out_ready(rot_ready),
		.out_item (rot_item)
	);

	rpd_rotate u_rotate (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (rot_valid),
		.in_ready (rot_ready),
		.in_item  (rot_item),
		.out_valid(delta_valid),
		.out_ready(delta_ready),
		.out_item (delta)
	);

endmodule

/* test/tb_top.sv */
// Self-checking testbench for relative_pose_delta_unit: directed table, then random pose pairs.
// Expected deltas: typed rows or an in-bench CORDIC/rotation predictor; needs rpd_pkg and RTL.
// Both handshake sides idle in random bursts; one long output hold-off and one drain pause.
module tb_top;

	localparam int N_RANDOM = 450;
	localparam int CALM_ITEMS = 80;
	localparam int HOLD_CYCLES = 100;
	localparam int HOLD_ITEMS = 60;
	localparam int DRAIN_CYCLES = 40;
	localparam int CYCLE_LIMIT = 200000;

	localparam logic signed [31:0] P_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] P_MIN = 32'sh8000_0000;
	localparam logic signed [15:0] H_MAX = 16'sh7FFF;
	localparam logic signed [15:0] H_MIN = 16'sh8000;
	localparam rpd_pkg::delta_t NO_DELTA = '0;

	localparam longint GAIN_INV = 64'sd652032874;
	localparam longint QUARTER_TURN = 64'sd1 <<< 30;
	localparam longint HALF_TURN = 64'sd1 <<< 31;
	localparam longint ARCTAN_TURNS [30] = '{
		64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
		64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
		64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
		64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
		64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
		64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001
	};

	localparam logic [31:0] POS_CORNERS [5] = '{32'h7FFFFFFF, 32'h80000000, 32'h0, 32'hFFFFFFFF, 32'h1};
	localparam logic [15:0] HEADING_CORNERS [7] = '{
		16'h7FFF, 16'h8000, 16'h0000, 16'h4000, 16'hC000, 16'h3FFF, 16'hBFFF
	};

	typedef struct {
		rpd_pkg::pose_t pose_in;
		bit typed;
		rpd_pkg::delta_t want;
	} pose_case_t;

	// Rows marked typed carry a result that follows directly from the geometry: zero motion,
	// heading wrap at half a turn, and displacements far past the clipping range.
	localparam int N_DIRECTED = 22;
	pose_case_t directed_rows [N_DIRECTED] = '{
		'{'{32'sd0, 32'sd0, 16'sd0, 32'sd0, 32'sd0, 16'sd0}, 1'b1, '{32'sd0, 32'sd0, 16'sd0, 1'b0}},
		'{'{32'sd1000, -32'sd5, H_MIN, 32'sd1000, -32'sd5, 16'sd0}, 1'b1,
			'{32'sd0, 32'sd0, H_MIN, 1'b0}},
		'{'{P_MAX, P_MIN, 16'sd0, P_MAX, P_MIN, H_MIN}, 1'b1, '{32'sd0, 32'sd0, H_MIN, 1'b0}},
		'{'{P_MIN, P_MIN, H_MIN, P_MIN, P_MIN, H_MAX}, 1'b1, '{32'sd0, 32'sd0, 16'sd1, 1'b0}},
		'{'{P_MAX, P_MAX, H_MAX, P_MAX, P_MAX, H_MIN}, 1'b1, '{32'sd0, 32'sd0, -16'sd1, 1'b0}},
		'{'{P_MAX, P_MAX, 16'sd0, P_MIN, P_MIN, 16'sd0}, 1'b1, '{P_MAX, P_MAX, 16'sd0, 1'b1}},
		'{'{P_MIN, P_MIN, 16'sd0, P_MAX, P_MAX, 16'sd0}, 1'b1, '{P_MIN, P_MIN, 16'sd0, 1'b1}},
		'{'{P_MAX, P_MAX, H_MIN, P_MIN, P_MIN, H_MIN}, 1'b1, '{P_MIN, P_MIN, 16'sd0, 1'b1}},
		'{'{P_MAX, P_MAX, 16'sd16384, P_MIN, P_MIN, 16'sd16384}, 1'b1,
			'{P_MAX, P_MIN, 16'sd0, 1'b1}},
		'{'{P_MAX, P_MAX, -16'sd16384, P_MIN, P_MIN, -16'sd16384}, 1'b1,
			'{P_MIN, P_MAX, 16'sd0, 1'b1}},
		'{'{32'sd65536, 32'sd0, 16'sd0, 32'sd0, 32'sd0, 16'sd0}, 1'b0, NO_DELTA},
		'{'{32'sd65536, 32'sd0, 16'sd8192, 32'sd0, 32'sd0, 16'sd8192}, 1'b0, NO_DELTA},
		'{'{32'sd300000, -32'sd70000, H_MAX, 32'sd0, 32'sd0, H_MAX}, 1'b0, NO_DELTA},
		'{'{-32'sd300000, 32'sd12345, -16'sd32767, 32'sd0, 32'sd0, -16'sd32767}, 1'b0, NO_DELTA},
		'{'{32'sd65536, 32'sd65536, 16'sd16383, 32'sd0, 32'sd0, 16'sd16383}, 1'b0, NO_DELTA},
		'{'{32'sd65536, 32'sd65536, -16'sd16384, 32'sd0, 32'sd0, -16'sd16384}, 1'b0, NO_DELTA},
		'{'{32'sd65536, 32'sd65536, -16'sd16385, 32'sd0, 32'sd0, -16'sd16385}, 1'b0, NO_DELTA},
		'{'{P_MAX, 32'sd0, 16'sd0, 32'sd0, 32'sd0, 16'sd0}, 1'b0, NO_DELTA},
		'{'{P_MIN, 32'sd0, 16'sd0, 32'sd0, 32'sd0, 16'sd0}, 1'b0, NO_DELTA},
		'{'{32'sd1, -32'sd1, 16'sd12345, 32'sd0, 32'sd0, 16'sd12345}, 1'b0, NO_DELTA},
		'{'{32'sd1, 32'sd0, 16'sd8192, 32'sd0, 32'sd0, 16'sd8192}, 1'b0, NO_DELTA},
		'{'{P_MAX, P_MIN, H_MAX, P_MIN, P_MAX, H_MIN}, 1'b0, NO_DELTA}
	};

	logic clk;
	logic arst_n = 1'b0;
	logic pose_valid = 1'b0;
	logic pose_ready;
	rpd_pkg::pose_t pose = '0;
	logic delta_valid;
	logic delta_ready = 1'b0;
	rpd_pkg::delta_t delta;

	rpd_pkg::delta_t pending_deltas [$];
	int n_errors = 0;
	int cycle_count = 0;
	bit calm = 1'b0;
	bit hold_off_req = 1'b0;
	int gapless_left = 0;

	relative_pose_delta_unit i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.pose_valid(pose_valid),
		.pose_ready(pose_ready),
		.pose(pose),
		.delta_valid(delta_valid),
		.delta_ready(delta_ready),
		.delta(delta)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Rounds a Q(.30) sum to nearest, halves up, and clips it to the 32-bit position range.
	function automatic logic signed [31:0] round_and_clip(input logic signed [127:0] sum,
			inout bit clipped);
		logic signed [127:0] v;
		v = (sum + (128'sd1 <<< 29)) >>> 30;
		if (v > 128'sd2147483647) begin
			clipped = 1'b1;
			return P_MAX;
		end
		if (v < -128'sd2147483648) begin
			clipped = 1'b1;
			return P_MIN;
		end
		return v[31:0];
	endfunction

	function automatic rpd_pkg::delta_t predict_delta(input rpd_pkg::pose_t p);
		longint dx, dy, cx, sy, z, xs, ys;
		logic signed [127:0] w_dx, w_dy, w_c, w_s;
		bit clipped;
		rpd_pkg::delta_t r;
		dx = longint'($signed(p.cur_x)) - longint'($signed(p.prev_x));
		dy = longint'($signed(p.cur_y)) - longint'($signed(p.prev_y));
		z = longint'($signed({p.prev_heading, 16'h0000}));
		cx = GAIN_INV;
		sy = 0;
		// Headings outside [-1/4, 1/4) turn start from the negated vector, half a turn away.
		if (z >= QUARTER_TURN) begin
			z -= HALF_TURN;
			cx = -cx;
		end else if (z < -QUARTER_TURN) begin
			z += HALF_TURN;
			cx = -cx;
		end
		for (int i = 0; i < 30; i++) begin
			xs = cx >>> i;
			ys = sy >>> i;
			if (z >= 0) begin
				cx -= ys;
				sy += xs;
				z -= ARCTAN_TURNS[i];
			end else begin
				cx += ys;
				sy -= xs;
				z += ARCTAN_TURNS[i];
			end
		end
		w_dx = dx;
		w_dy = dy;
		w_c = cx;
		w_s = sy;
		clipped = 1'b0;
		r.forward = round_and_clip(w_dx * w_c + w_dy * w_s, clipped);
		r.lateral = round_and_clip(w_dy * w_c - w_dx * w_s, clipped);
		r.turn = p.cur_heading - p.prev_heading;
		r.saturated = clipped;
		return r;
	endfunction

	// Offers one pose transaction, possibly after an idle burst, and returns in the time step
	// of the clock edge that accepts it.
	task automatic offer_pose(input rpd_pkg::pose_t p, input rpd_pkg::delta_t want);
		if (gapless_left > 0) begin
			gapless_left--;
		end else if (!calm && $urandom_range(0, 3) == 0) begin
			pose_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		pose <= p;
		pose_valid <= 1'b1;
		do @(negedge clk); while (!pose_ready);
		pending_deltas = {pending_deltas, want};
		@(posedge clk);
	endtask

	task automatic check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			n_errors++;
		end
	endtask

	// Outputs are stable at the falling edge; a transaction seen here completes at the next rise.
	always @(negedge clk) begin
		rpd_pkg::delta_t want;
		if (arst_n && delta_valid && delta_ready) begin
			if (pending_deltas.size() == 0) begin
				$error("delta transaction with no pose pending: forward %0d lateral %0d",
					delta.forward, delta.lateral);
				n_errors++;
			end else begin
				want = pending_deltas.pop_front();
				check_field("forward", want.forward, delta.forward);
				check_field("lateral", want.lateral, delta.lateral);
				check_field("turn", want.turn, delta.turn);
				check_field("saturated", want.saturated, delta.saturated);
			end
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		forever begin
			if (hold_off_req) begin
				delta_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off_req = 1'b0;
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				delta_ready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end else begin
				delta_ready <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	end

	initial begin
		rpd_pkg::pose_t cand;
		int mode;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIRECTED; i++) begin
			offer_pose(directed_rows[i].pose_in, directed_rows[i].typed ?
				directed_rows[i].want : predict_delta(directed_rows[i].pose_in));
		end

		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == 150) begin
				hold_off_req = 1'b1;
				gapless_left = HOLD_ITEMS;
			end
			if (i == 300) begin
				pose_valid <= 1'b0;
				@(posedge clk);
				while (pending_deltas.size() != 0) @(posedge clk);
			end
			if (i == N_RANDOM - CALM_ITEMS)
				calm = 1'b1;

			cand = {$urandom(), $urandom(), 16'($urandom()), $urandom(), $urandom(),
				16'($urandom())};
			mode = $urandom_range(0, 9);
			case (mode)
				0, 1, 2, 3, 4: begin
					// Ordinary odometry step: small displacement and small heading change.
					cand.cur_x = cand.prev_x + 32'($urandom_range(0, 2097152)) - 32'sd1048576;
					cand.cur_y = cand.prev_y + 32'($urandom_range(0, 2097152)) - 32'sd1048576;
					cand.cur_heading = cand.prev_heading + 16'($urandom_range(0, 4096))
						- 16'sd2048;
				end
				8: begin
					cand.cur_x = POS_CORNERS[$urandom_range(0, 4)];
					cand.cur_y = POS_CORNERS[$urandom_range(0, 4)];
					cand.prev_x = POS_CORNERS[$urandom_range(0, 4)];
					cand.prev_y = POS_CORNERS[$urandom_range(0, 4)];
					cand.cur_heading = HEADING_CORNERS[$urandom_range(0, 6)];
					cand.prev_heading = HEADING_CORNERS[$urandom_range(0, 6)];
				end
				9: begin
					cand.cur_x = cand.prev_x;
					cand.cur_y = cand.prev_y;
				end
				default: ;
			endcase
			offer_pose(cand, predict_delta(cand));
		end

		pose_valid <= 1'b0;
		while (pending_deltas.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (n_errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
